@@ sv/hdg_pkg.sv @@
// Package for the heading-then-drive goal controller: widths, modes, sequencer
// states, register indexes, channel payloads and the arctangent table.
// Depends on nothing; hdg_cordic, the top level and hdg_checker import it.
package hdg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int OFS_W            = 33;  // goal minus position, exact
    localparam int CORDIC_W         = 36;  // rotated vector with gain headroom
    localparam int ATAN_IDX_W       = 5;
    localparam int SQ_IN_W          = 31;
    localparam int SQ_OUT_W         = 62;

    typedef enum logic [1:0] {
        MODE_FIX   = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_DONE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_TOL,
        ST_DECIDE
    } state_t;

    typedef enum logic [2:0] {
        CFG_ENABLE        = 3'd0,
        CFG_GOAL_X        = 3'd1,
        CFG_GOAL_Y        = 3'd2,
        CFG_HEADING_TOL   = 3'd3,
        CFG_DISTANCE_TOL  = 3'd4,
        CFG_TURN_LEFT     = 3'd5,
        CFG_TURN_RIGHT    = 3'd6,
        CFG_FORWARD_SPEED = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic               cmd_valid;
        logic signed [15:0] cmd_linear;
        logic signed [15:0] cmd_angular;
        logic [1:0]         mode_after;
        logic               at_goal;
    } cmd_t;

    typedef struct packed {
        cfg_idx_t    index;
        logic [31:0] value;
    } cfg_t;

    localparam logic [14:0]        HTOL_RST  = 15'd377;
    localparam logic [30:0]        DTOL_RST  = 31'd19661;
    localparam logic signed [15:0] LEFT_RST  = 16'sd77;
    localparam logic signed [15:0] RIGHT_RST = -16'sd77;
    localparam logic signed [15:0] FWD_RST   = 16'sd179;

    // atan(2^-i) as a 32-bit binary angle, pi = 2^31
    function automatic logic [31:0] hdg_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051D;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2E;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000028;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000002;
            5'd29:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ sv/hdg_stream_if.sv @@
// Valid/ready channel carrying one payload struct per transfer.
// Payload type comes from hdg_pkg at the point of instantiation.
interface hdg_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ sv/hdg_cordic.sv @@
// Iterative vectoring CORDIC: bearing of (dx, dy) as a binary angle.
// One micro-rotation per cycle on a shared add/subtract and shift; uses hdg_pkg.
module hdg_cordic #(
    parameter int CORDIC_STEPS = hdg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = hdg_pkg::ANGLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hdg_pkg::OFS_W-1:0]  dx,
    input  logic signed [hdg_pkg::OFS_W-1:0]  dy,
    output logic                              done,
    output logic [ANGLE_BITS-1:0]             angle
);
    import hdg_pkg::*;

    localparam int SH     = 32 - ANGLE_BITS;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0]     LAST    = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [32:0]           RND     = 33'd1 << (SH - 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] NQUARTER = {2'b11, {(ANGLE_BITS - 2){1'b0}}};

    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic [ANGLE_BITS-1:0]      z_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg, done_reg, zero_reg;

    logic signed [CORDIC_W-1:0] dx_w, dy_w, x0, y0, x_sh, y_sh;
    logic [ANGLE_BITS-1:0]      z0, t;
    logic [32:0]                tab_rnd;
    logic                       y_pos;

    assign dx_w = {{(CORDIC_W - OFS_W){dx[OFS_W-1]}}, dx};
    assign dy_w = {{(CORDIC_W - OFS_W){dy[OFS_W-1]}}, dy};

    // pre-rotate a quarter turn when the vector points into the left half plane
    always_comb
    begin
        x0 = dx_w;
        y0 = dy_w;
        z0 = '0;
        if (dx_w[CORDIC_W-1])
        begin
            if (!dy_w[CORDIC_W-1])
            begin
                x0 = dy_w;
                y0 = -dx_w;
                z0 = QUARTER;
            end
            else
            begin
                x0 = -dy_w;
                y0 = dx_w;
                z0 = NQUARTER;
            end
        end
    end

    assign x_sh    = x_reg >>> step_reg;
    assign y_sh    = y_reg >>> step_reg;
    assign tab_rnd = ({1'b0, hdg_atan(ATAN_IDX_W'(step_reg))} + RND) >> SH;
    assign t       = tab_rnd[ANGLE_BITS-1:0];
    assign y_pos   = !y_reg[CORDIC_W-1] && (y_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            zero_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            zero_reg <= (dx == '0) && (dy == '0);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= z0;
        end
        else if (busy_reg)
        begin
            // rotate towards the x axis
            if (y_pos)
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + t;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - t;
            end
        end
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_reg;

endmodule

@@ sv/heading_then_drive_goal_controller.sv @@
// Top level of the heading-then-drive goal controller.
// Uses hdg_pkg, hdg_stream_if and hdg_cordic.
//
// Each pose transfer (position in signed Q16.16 metres, heading as a 16-bit
// binary angle with pi at 2^15) yields exactly one command transfer. The block
// finds the bearing to the goal with an iterative CORDIC, wraps the heading
// error to one turn and compares squared distance with the squared arrival
// radius on one shared 31x31 multiplier. Three modes: fix heading turns left or
// right until the error is inside tolerance, drive issues forward speed until
// inside the radius, done issues a stop; a large error returns to fix heading.
// While disabled a tick issues no command and the mode holds. Between a pose
// transfer and the next, the sequencer runs the CORDIC micro-rotations, a step
// that captures the error test, three squaring steps, one decision step and the
// idle state with ready high. The CORDIC does one micro-rotation per cycle; the
// pose channel is not ready meanwhile. A finished command waits in an output
// register, so the next pose is taken while it is unclaimed; if it is still
// unclaimed when the next decision is due, the sequencer holds in its decision
// step until that command transfers. Configuration writes are taken every
// cycle and are meant to land while no pose is in flight.
module heading_then_drive_goal_controller #(
    parameter int CORDIC_STEPS = hdg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = hdg_pkg::ANGLE_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    hdg_stream_if.sink   pose,
    hdg_stream_if.source cmd,
    hdg_stream_if.sink   cfg
);
    import hdg_pkg::*;

    localparam int SH = 32 - ANGLE_BITS;

    // configuration registers
    logic               enable_reg;
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [14:0]        htol_reg;
    logic [30:0]        dtol_reg;
    logic signed [15:0] left_reg, right_reg, fwd_reg;

    // sequencer and working registers
    state_t                    state_reg, state_next;
    mode_t                     mode_reg, mode_next;
    logic signed [OFS_W-1:0]   dx_reg, dy_reg;
    logic signed [15:0]        heading_reg;
    logic                      yaw_bad_reg, yaw_bad_next;
    logic                      neg_reg, neg_next;
    logic                      big_reg, big_next;
    logic [SQ_OUT_W-1:0]       prod_reg, prod_next;
    logic [SQ_OUT_W:0]         sum_reg, sum_next;
    cmd_t                      out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      pose_xfer, cmd_xfer;
    logic signed [OFS_W-1:0]   dx_in, dy_in;
    logic                      cordic_done;
    logic [ANGLE_BITS-1:0]     bearing;
    logic [31:0]               err, mag;
    logic [OFS_W-1:0]          ax, ay;
    logic [SQ_IN_W-1:0]        mul_op;
    logic [SQ_OUT_W-1:0]       prod_w;

    assign pose_xfer = pose.valid && pose.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign pose.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign cmd.valid  = out_valid_reg;
    assign cmd.data   = out_reg;

    // offsets to the goal are exact at 33 bits
    assign dx_in = {goal_x_reg[31], goal_x_reg} - {pose.data.pos_x[31], pose.data.pos_x};
    assign dy_in = {goal_y_reg[31], goal_y_reg} - {pose.data.pos_y[31], pose.data.pos_y};

    hdg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pose_xfer),
        .dx    (dx_in),
        .dy    (dy_in),
        .done  (cordic_done),
        .angle (bearing)
    );

    // heading error at pi = 2^31, wrapped modulo one turn
    assign err = {bearing, {SH{1'b0}}} - {heading_reg, 16'b0};
    assign mag = err[31] ? (~err + 32'd1) : err;

    // magnitudes of the offsets; anything at or above 2^31 is outside the radius
    assign ax = dx_reg[OFS_W-1] ? (~dx_reg + 1'b1) : dx_reg;
    assign ay = dy_reg[OFS_W-1] ? (~dy_reg + 1'b1) : dy_reg;

    // shared squaring multiplier, operand chosen by the sequencer
    always_comb
    begin
        case (state_reg)
            ST_SQ_X: mul_op = ax[SQ_IN_W-1:0];
            ST_SQ_Y: mul_op = ay[SQ_IN_W-1:0];
            default: mul_op = dtol_reg;
        endcase
    end

    assign prod_w = SQ_OUT_W'(mul_op) * SQ_OUT_W'(mul_op);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            htol_reg   <= HTOL_RST;
            dtol_reg   <= DTOL_RST;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            fwd_reg    <= FWD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                CFG_ENABLE:        enable_reg <= cfg.data.value[0];
                CFG_GOAL_X:        goal_x_reg <= cfg.data.value;
                CFG_GOAL_Y:        goal_y_reg <= cfg.data.value;
                CFG_HEADING_TOL:   htol_reg   <= cfg.data.value[14:0];
                CFG_DISTANCE_TOL:  dtol_reg   <= cfg.data.value[30:0];
                CFG_TURN_LEFT:     left_reg   <= cfg.data.value[15:0];
                CFG_TURN_RIGHT:    right_reg  <= cfg.data.value[15:0];
                CFG_FORWARD_SPEED: fwd_reg    <= cfg.data.value[15:0];
                default:           ;
            endcase
        end
    end

    // sequencer: next state, working values and the command
    always_comb
    begin
        logic  far;
        logic  issue;
        mode_t m;

        state_next     = state_reg;
        mode_next      = mode_reg;
        yaw_bad_next   = yaw_bad_reg;
        neg_next       = neg_reg;
        big_next       = big_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !cmd_xfer;
        far            = big_reg || (sum_reg > {1'b0, prod_reg});
        issue          = !out_valid_reg || cmd.ready;
        m              = mode_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pose_xfer)
                begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                // capture the error test once the bearing is final
                if (cordic_done)
                begin
                    yaw_bad_next = mag > {1'b0, htol_reg, 16'b0};
                    neg_next     = err[31];
                    state_next   = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                big_next   = ax[OFS_W-1] | ax[OFS_W-2] | ay[OFS_W-1] | ay[OFS_W-2];
                prod_next  = prod_w;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                sum_next   = {1'b0, prod_reg};
                prod_next  = prod_w;
                state_next = ST_SQ_TOL;
            end
            ST_SQ_TOL:
            begin
                sum_next   = sum_reg + {1'b0, prod_reg};
                prod_next  = prod_w;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold until the output register is free
                if (issue)
                begin
                    out_next.cmd_valid   = 1'b0;
                    out_next.cmd_linear  = '0;
                    out_next.cmd_angular = '0;
                    out_next.at_goal     = 1'b0;
                    if (enable_reg)
                    begin
                        case (mode_reg)
                            MODE_DRIVE:
                            begin
                                if (far)
                                begin
                                    out_next.cmd_valid  = 1'b1;
                                    out_next.cmd_linear = fwd_reg;
                                end
                                else
                                begin
                                    m = MODE_DONE;
                                end
                                if (yaw_bad_reg)
                                begin
                                    m = MODE_FIX;
                                end
                            end
                            MODE_DONE:
                            begin
                                out_next.cmd_valid = 1'b1;
                                out_next.at_goal   = 1'b1;
                                if (yaw_bad_reg)
                                begin
                                    m = MODE_FIX;
                                end
                            end
                            default:
                            begin
                                if (yaw_bad_reg)
                                begin
                                    m = MODE_FIX;
                                    out_next.cmd_valid   = 1'b1;
                                    out_next.cmd_angular = neg_reg ? right_reg : left_reg;
                                end
                                else
                                begin
                                    m = MODE_DRIVE;
                                end
                            end
                        endcase
                    end
                    mode_next           = m;
                    out_next.mode_after = 2'(m);
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FIX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pose_xfer)
        begin
            dx_reg      <= dx_in;
            dy_reg      <= dy_in;
            heading_reg <= pose.data.heading;
        end
        yaw_bad_reg <= yaw_bad_next;
        neg_reg     <= neg_next;
        big_reg     <= big_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        out_reg     <= out_next;
    end

endmodule

@@ sv/hdg_checker.sv @@
// Port-level checks for the goal controller, attached by the bind below.
// Depends on hdg_pkg and heading_then_drive_goal_controller.
module hdg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input hdg_pkg::cmd_t out_data
);
    import hdg_pkg::*;

    // a taken pose keeps the block busy
    a_busy_after_pose: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pose channel ready right after a pose transfer");

    // a new command only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("command appeared without a pose in flight");

    // done mode issues a stop
    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.at_goal |-> out_data.cmd_valid
            && (out_data.cmd_linear == 16'sd0) && (out_data.cmd_angular == 16'sd0))
        else $error("at_goal command is not a stop");

    // a stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled command changed");

endmodule

bind heading_then_drive_goal_controller hdg_checker u_hdg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pose.valid),
    .in_ready  (pose.ready),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .out_data  (cmd.data)
);
